@@ rtl/multi_channel_history_store_core_assert.svh @@
// Assertion helpers; expect clk_i and rst_ni in scope
`ifndef MULTI_CHANNEL_HISTORY_STORE_CORE_ASSERT_SVH
`define MULTI_CHANNEL_HISTORY_STORE_CORE_ASSERT_SVH

`define MCHS_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

`define MCHS_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define MCHS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mchs_pkg.sv @@
package mchs_pkg;

  localparam int MAX_STACKS        = 8;
  localparam int HISTORY_DEPTH     = 8;
  localparam int MAX_ELEMENT_BYTES = 8;
  localparam int CAPACITY_BYTES    = 512;

  localparam int SLOT_W    = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int POS_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FILL_W    = $clog2(HISTORY_DEPTH + 1);
  localparam int RAM_DEPTH = MAX_STACKS * HISTORY_DEPTH;
  localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam int BUDGET_W  = $clog2(CAPACITY_BYTES + 1);
  localparam int COST_W    = $clog2(MAX_ELEMENT_BYTES * HISTORY_DEPTH + 1);
  localparam int CALC_W    = (BUDGET_W > COST_W) ? BUDGET_W : COST_W;

  localparam int CMD_W     = 3;
  localparam int ID_W      = 8;
  localparam int ESZ_W     = 4;
  localparam int DATA_W    = 64;
  localparam int IDX_OUT_W = 6;
  localparam int COUNT_W   = 7;

  localparam logic [CMD_W-1:0] CMD_CREATE      = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_REMOVE      = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_WRITE       = CMD_W'(2);
  localparam logic [CMD_W-1:0] CMD_READ_LATEST = CMD_W'(3);
  localparam logic [CMD_W-1:0] CMD_READ_ALL    = CMD_W'(4);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

@@ rtl/mchs_cmd_if.sv @@
interface mchs_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [mchs_pkg::CMD_W-1:0]     command;
  logic [mchs_pkg::ID_W-1:0]      chan_id;
  logic [mchs_pkg::ESZ_W-1:0]     elem_bytes;
  logic [mchs_pkg::DATA_W-1:0]    entry_data;

  modport source (output valid, command, chan_id, elem_bytes, entry_data, input ready);
  modport sink   (input valid, command, chan_id, elem_bytes, entry_data, output ready);
endinterface

@@ rtl/mchs_rsp_if.sv @@
interface mchs_rsp_if;
  logic                            valid;
  logic                            ready;
  mchs_pkg::status_e               status;
  logic [mchs_pkg::ID_W-1:0]       new_id;
  logic [mchs_pkg::DATA_W-1:0]     read_data;
  logic [mchs_pkg::IDX_OUT_W-1:0]  entry_index;
  logic [mchs_pkg::COUNT_W-1:0]    entry_count;
  logic                            last;

  modport source (output valid, status, new_id, read_data, entry_index, entry_count, last,
                  input ready);
  modport sink   (input valid, status, new_id, read_data, entry_index, entry_count, last,
                  output ready);
endinterface

@@ rtl/mchs_entry_ram.sv @@
module mchs_entry_ram (
  input  logic                        clk_i,
  input  mchs_pkg::ram_req_t          req_i,
  output logic [mchs_pkg::DATA_W-1:0] rdata_o
);

  logic [mchs_pkg::DATA_W-1:0] mem_q [mchs_pkg::RAM_DEPTH];
  logic [mchs_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/multi_channel_history_store_core.sv @@
// Channel  Dir  Payload                                                    Accept
// cmd_i    in   command, chan_id, elem_bytes, entry_data                   valid & ready
// rsp_o    out  status, new_id, read_data, entry_index, entry_count, last  valid & ready
//
// A defined command scans the slot table one slot a cycle (up to MAX_STACKS slots), then
// enters execute; create, remove, write and failed commands finish there.
// Reads of a non-empty channel then repeat an entry RAM read and an output load per entry.
// cmd_i.ready is high only between commands; rsp_o is a register, so a stalled
// result holds the block in execute or output load until taken.
// Reset clears the slot table, sets the budget to CAPACITY_BYTES and the id counter to 1; the entry RAM is not cleared.
module multi_channel_history_store_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  mchs_cmd_if.sink    cmd_i,
  mchs_rsp_if.source  rsp_o
);

  `include "multi_channel_history_store_core_assert.svh"

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EXEC, S_RD, S_RDOUT} state_e;

  function automatic logic [mchs_pkg::DATA_W-1:0] byte_mask(
    input logic [mchs_pkg::ESZ_W-1:0] nbytes);
    logic [mchs_pkg::DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < mchs_pkg::DATA_W / 8; b++) begin
      m[b*8 +: 8] = {8{mchs_pkg::ESZ_W'(b) < nbytes}};
    end
    return m;
  endfunction

  function automatic logic [mchs_pkg::ADDR_W-1:0] ram_addr(
    input logic [mchs_pkg::SLOT_W-1:0] slot, input logic [mchs_pkg::POS_W-1:0] pos);
    return mchs_pkg::ADDR_W'(slot) * mchs_pkg::ADDR_W'(mchs_pkg::HISTORY_DEPTH)
           + mchs_pkg::ADDR_W'(pos);
  endfunction

  state_e                             state_q;
  logic [mchs_pkg::CMD_W-1:0]         cmd_q;
  logic [mchs_pkg::ID_W-1:0]          id_q;
  logic [mchs_pkg::ESZ_W-1:0]         esz_q;
  logic [mchs_pkg::DATA_W-1:0]        data_q;
  logic [mchs_pkg::SLOT_W-1:0]        scan_q;
  logic                               found_q;
  logic [mchs_pkg::SLOT_W-1:0]        hit_slot_q;
  logic [mchs_pkg::ESZ_W-1:0]         sel_bytes_q;
  logic [mchs_pkg::FILL_W-1:0]        sel_fill_q;
  logic [mchs_pkg::POS_W-1:0]         sel_pos_q;
  logic [mchs_pkg::POS_W-1:0]         rd_k_q;
  logic [mchs_pkg::POS_W-1:0]         rd_pos_q;

  logic                               slot_valid_q [mchs_pkg::MAX_STACKS];
  logic [mchs_pkg::ID_W-1:0]          slot_id_q    [mchs_pkg::MAX_STACKS];
  logic [mchs_pkg::ESZ_W-1:0]         slot_bytes_q [mchs_pkg::MAX_STACKS];
  logic [mchs_pkg::FILL_W-1:0]        slot_fill_q  [mchs_pkg::MAX_STACKS];
  logic [mchs_pkg::POS_W-1:0]         slot_pos_q   [mchs_pkg::MAX_STACKS];
  logic [mchs_pkg::BUDGET_W-1:0]      budget_q;
  logic [mchs_pkg::ID_W-1:0]          next_id_q;

  logic                               rsp_valid_q;
  mchs_pkg::status_e                  rsp_status_q;
  logic [mchs_pkg::ID_W-1:0]          rsp_new_id_q;
  logic [mchs_pkg::DATA_W-1:0]        rsp_data_q;
  logic [mchs_pkg::IDX_OUT_W-1:0]     rsp_index_q;
  logic [mchs_pkg::COUNT_W-1:0]       rsp_count_q;
  logic                               rsp_last_q;

  logic                               accept;
  logic                               out_free;
  logic [mchs_pkg::ESZ_W-1:0]         esz_clamp;
  logic                               hit;
  logic                               scan_last;
  logic [mchs_pkg::ESZ_W-1:0]         cost_bytes;
  logic [mchs_pkg::CALC_W-1:0]        cost;
  logic [mchs_pkg::CALC_W-1:0]        budget_ext;
  logic [mchs_pkg::POS_W-1:0]         wr_pos;
  logic [mchs_pkg::FILL_W-1:0]        new_fill;
  logic                               rd_last;
  logic                               create_ok;
  logic                               rm_ok;
  logic                               wr_ok;
  logic                               rd_cmd;
  logic                               rd_start;
  logic                               rsp_load;
  mchs_pkg::status_e                  exec_status;
  logic [mchs_pkg::DATA_W-1:0]        ram_rdata;
  mchs_pkg::ram_req_t                 ram_req;

  assign accept   = cmd_i.valid && cmd_i.ready;
  assign out_free = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    esz_clamp = cmd_i.elem_bytes;
    if (cmd_i.elem_bytes == '0) begin
      esz_clamp = mchs_pkg::ESZ_W'(1);
    end else if (cmd_i.elem_bytes > mchs_pkg::ESZ_W'(mchs_pkg::MAX_ELEMENT_BYTES)) begin
      esz_clamp = mchs_pkg::ESZ_W'(mchs_pkg::MAX_ELEMENT_BYTES);
    end
  end

  // shared slot comparator
  assign hit = (cmd_q == mchs_pkg::CMD_CREATE) ? !slot_valid_q[scan_q]
             : (slot_valid_q[scan_q] && (slot_id_q[scan_q] == id_q));
  assign scan_last = (scan_q == mchs_pkg::SLOT_W'(mchs_pkg::MAX_STACKS - 1));

  // shared cost unit: create charges, remove refunds
  assign cost_bytes = (cmd_q == mchs_pkg::CMD_CREATE) ? esz_q : sel_bytes_q;
  assign cost       = mchs_pkg::CALC_W'(cost_bytes)
                    * mchs_pkg::CALC_W'(mchs_pkg::HISTORY_DEPTH);
  assign budget_ext = mchs_pkg::CALC_W'(budget_q);

  always_comb begin
    wr_pos = '0;
    if (sel_fill_q != '0 && sel_pos_q != mchs_pkg::POS_W'(mchs_pkg::HISTORY_DEPTH - 1)) begin
      wr_pos = sel_pos_q + mchs_pkg::POS_W'(1);
    end
  end

  assign new_fill = (sel_fill_q == mchs_pkg::FILL_W'(mchs_pkg::HISTORY_DEPTH))
                  ? sel_fill_q : sel_fill_q + mchs_pkg::FILL_W'(1);
  assign rd_last  = (cmd_q == mchs_pkg::CMD_READ_LATEST)
                 || ((mchs_pkg::FILL_W'(rd_k_q) + mchs_pkg::FILL_W'(1)) == sel_fill_q);

  assign create_ok = (cmd_q == mchs_pkg::CMD_CREATE) && found_q && (cost <= budget_ext);
  assign rm_ok     = found_q && (cmd_q == mchs_pkg::CMD_REMOVE);
  assign wr_ok     = found_q && (cmd_q == mchs_pkg::CMD_WRITE);
  assign rd_cmd    = cmd_q inside {mchs_pkg::CMD_READ_LATEST, mchs_pkg::CMD_READ_ALL};
  assign rd_start  = found_q && rd_cmd && (sel_fill_q != '0);
  assign rsp_load  = out_free && (((state_q == S_EXEC) && !rd_start) || (state_q == S_RDOUT));

  always_comb begin
    exec_status = mchs_pkg::ST_OK;
    if (cmd_q == mchs_pkg::CMD_CREATE) begin
      if (!create_ok) begin
        exec_status = mchs_pkg::ST_FULL;
      end
    end else if (!found_q) begin
      exec_status = mchs_pkg::ST_INVALID;
    end else if (rd_cmd && (sel_fill_q == '0)) begin
      exec_status = mchs_pkg::ST_EMPTY;
    end
  end

  always_comb begin
    ram_req.we    = (state_q == S_EXEC) && out_free && found_q
                 && (cmd_q == mchs_pkg::CMD_WRITE);
    ram_req.waddr = ram_addr(hit_slot_q, wr_pos);
    ram_req.wdata = data_q & byte_mask(sel_bytes_q);
    ram_req.re    = (state_q == S_RD);
    ram_req.raddr = ram_addr(hit_slot_q, rd_pos_q);
  end

  mchs_entry_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= '0;
      id_q         <= '0;
      esz_q        <= '0;
      data_q       <= '0;
      scan_q       <= '0;
      found_q      <= 1'b0;
      hit_slot_q   <= '0;
      sel_bytes_q  <= '0;
      sel_fill_q   <= '0;
      sel_pos_q    <= '0;
      rd_k_q       <= '0;
      rd_pos_q     <= '0;
      for (int s = 0; s < mchs_pkg::MAX_STACKS; s++) begin
        slot_valid_q[s] <= 1'b0;
        slot_id_q[s]    <= '0;
        slot_bytes_q[s] <= '0;
        slot_fill_q[s]  <= '0;
        slot_pos_q[s]   <= '0;
      end
      budget_q     <= mchs_pkg::BUDGET_W'(mchs_pkg::CAPACITY_BYTES);
      next_id_q    <= mchs_pkg::ID_W'(1);
      rsp_valid_q  <= 1'b0;
      rsp_status_q <= mchs_pkg::ST_OK;
      rsp_new_id_q <= '0;
      rsp_data_q   <= '0;
      rsp_index_q  <= '0;
      rsp_count_q  <= '0;
      rsp_last_q   <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q   <= cmd_i.command;
            id_q    <= cmd_i.chan_id;
            esz_q   <= esz_clamp;
            data_q  <= cmd_i.entry_data;
            scan_q  <= '0;
            found_q <= 1'b0;
            if (cmd_i.command <= mchs_pkg::CMD_READ_ALL) begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            found_q     <= 1'b1;
            hit_slot_q  <= scan_q;
            sel_bytes_q <= slot_bytes_q[scan_q];
            sel_fill_q  <= slot_fill_q[scan_q];
            sel_pos_q   <= slot_pos_q[scan_q];
            state_q     <= S_EXEC;
          end else if (scan_last) begin
            state_q <= S_EXEC;
          end else begin
            scan_q <= scan_q + mchs_pkg::SLOT_W'(1);
          end
        end
        S_EXEC: begin
          if (out_free) begin
            if (rd_start) begin
              rd_k_q   <= '0;
              rd_pos_q <= sel_pos_q;
              state_q  <= S_RD;
            end else begin
              rsp_status_q <= exec_status;
              rsp_new_id_q <= create_ok ? next_id_q : '0;
              rsp_data_q   <= '0;
              rsp_index_q  <= '0;
              rsp_count_q  <= wr_ok ? mchs_pkg::COUNT_W'(new_fill) : '0;
              rsp_last_q   <= 1'b1;
              state_q      <= S_IDLE;
            end
            if (create_ok) begin
              slot_valid_q[hit_slot_q] <= 1'b1;
              slot_id_q[hit_slot_q]    <= next_id_q;
              slot_bytes_q[hit_slot_q] <= esz_q;
              slot_fill_q[hit_slot_q]  <= '0;
              slot_pos_q[hit_slot_q]   <= '0;
              budget_q  <= mchs_pkg::BUDGET_W'(budget_ext - cost);
              next_id_q <= (next_id_q == '1) ? mchs_pkg::ID_W'(1)
                                             : next_id_q + mchs_pkg::ID_W'(1);
            end else if (rm_ok) begin
              slot_valid_q[hit_slot_q] <= 1'b0;
              slot_fill_q[hit_slot_q]  <= '0;
              slot_pos_q[hit_slot_q]   <= '0;
              budget_q <= mchs_pkg::BUDGET_W'(budget_ext + cost);
            end else if (wr_ok) begin
              slot_fill_q[hit_slot_q] <= new_fill;
              slot_pos_q[hit_slot_q]  <= wr_pos;
            end
          end
        end
        S_RD: begin
          state_q <= S_RDOUT;
        end
        S_RDOUT: begin
          if (out_free) begin
            rsp_status_q <= mchs_pkg::ST_OK;
            rsp_new_id_q <= '0;
            rsp_data_q   <= ram_rdata;
            rsp_index_q  <= mchs_pkg::IDX_OUT_W'(rd_k_q);
            rsp_count_q  <= mchs_pkg::COUNT_W'(sel_fill_q);
            rsp_last_q   <= rd_last;
            if (rd_last) begin
              state_q <= S_IDLE;
            end else begin
              rd_k_q   <= rd_k_q + mchs_pkg::POS_W'(1);
              rd_pos_q <= (rd_pos_q == '0) ? mchs_pkg::POS_W'(mchs_pkg::HISTORY_DEPTH - 1)
                                           : rd_pos_q - mchs_pkg::POS_W'(1);
              state_q  <= S_RD;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.new_id      = rsp_new_id_q;
  assign rsp_o.read_data   = rsp_data_q;
  assign rsp_o.entry_index = rsp_index_q;
  assign rsp_o.entry_count = rsp_count_q;
  assign rsp_o.last        = rsp_last_q;

  `MCHS_ASSERT(a_budget_cap, budget_q <= mchs_pkg::BUDGET_W'(mchs_pkg::CAPACITY_BYTES), "budget above capacity")
  `MCHS_ASSERT(a_fill_cap, sel_fill_q <= mchs_pkg::FILL_W'(mchs_pkg::HISTORY_DEPTH), "fill above depth")
  `MCHS_IMPLIES(a_read_hit, ram_req.re, found_q && (sel_fill_q != '0), "entry read without live data")
  `MCHS_NEXT(a_busy_after_cmd, accept && (cmd_i.command <= mchs_pkg::CMD_READ_ALL), !cmd_i.ready, "ready during command")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;

  localparam logic [mchs_pkg::CMD_W-1:0] CMD_RSVD_FIRST = mchs_pkg::CMD_READ_ALL + 1'b1;
  localparam logic [mchs_pkg::CMD_W-1:0] CMD_RSVD_LAST  = '1;

  typedef struct {
    mchs_pkg::status_e                status;
    logic [mchs_pkg::ID_W-1:0]        new_id;
    logic [mchs_pkg::DATA_W-1:0]      data;
    logic [mchs_pkg::IDX_OUT_W-1:0]   idx;
    logic [mchs_pkg::COUNT_W-1:0]     count;
    logic                             last;
  } rsp_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  mchs_cmd_if cmd_if ();
  mchs_rsp_if rsp_if ();

  multi_channel_history_store_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // history store shadow
  logic                        ch_live  [mchs_pkg::MAX_STACKS];
  logic [mchs_pkg::ID_W-1:0]   ch_id    [mchs_pkg::MAX_STACKS];
  int unsigned                 ch_bytes [mchs_pkg::MAX_STACKS];
  int unsigned                 ch_fill  [mchs_pkg::MAX_STACKS];
  int unsigned                 ch_head  [mchs_pkg::MAX_STACKS];
  logic [mchs_pkg::DATA_W-1:0] hist_mem [mchs_pkg::MAX_STACKS][mchs_pkg::HISTORY_DEPTH];
  int unsigned                 budget_left;
  logic [mchs_pkg::ID_W-1:0]   id_counter;
  logic [mchs_pkg::ID_W-1:0]   last_created_id;

  rsp_beat_t expected_rsp_q[$];
  rsp_beat_t exp_beat;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int rx_hold_left = 0;
  int error_count  = 0;
  int beats_checked = 0;
  int cmds_sent    = 0;
  int cmd_hist [8];
  int cycle_cnt    = 0;

  function automatic rsp_beat_t make_beat(mchs_pkg::status_e st,
                                          logic [mchs_pkg::ID_W-1:0] nid,
                                          logic [mchs_pkg::DATA_W-1:0] d, int unsigned k,
                                          int unsigned cnt, logic lst);
    rsp_beat_t b;
    b.status = st;
    b.new_id = nid;
    b.data   = d;
    b.idx    = mchs_pkg::IDX_OUT_W'(k);
    b.count  = mchs_pkg::COUNT_W'(cnt);
    b.last   = lst;
    return b;
  endfunction

  function automatic void reset_shadow();
    for (int s = 0; s < mchs_pkg::MAX_STACKS; s++) begin
      ch_live[s]  = 1'b0;
      ch_id[s]    = '0;
      ch_bytes[s] = 0;
      ch_fill[s]  = 0;
      ch_head[s]  = 0;
      for (int p = 0; p < mchs_pkg::HISTORY_DEPTH; p++) hist_mem[s][p] = '0;
    end
    budget_left     = mchs_pkg::CAPACITY_BYTES;
    id_counter      = mchs_pkg::ID_W'(1);
    last_created_id = '0;
  endfunction

  function automatic int find_channel(logic [mchs_pkg::ID_W-1:0] id);
    for (int s = 0; s < mchs_pkg::MAX_STACKS; s++)
      if (ch_live[s] && ch_id[s] == id) return s;
    return -1;
  endfunction

  function automatic int first_live_slot();
    for (int s = 0; s < mchs_pkg::MAX_STACKS; s++)
      if (ch_live[s]) return s;
    return -1;
  endfunction

  function automatic void predict_history_cmd(logic [mchs_pkg::CMD_W-1:0] cmd,
                                              logic [mchs_pkg::ID_W-1:0] id,
                                              logic [mchs_pkg::ESZ_W-1:0] esz,
                                              logic [mchs_pkg::DATA_W-1:0] data);
    int s;
    int unsigned bytes;
    int unsigned cost;
    int unsigned pos;
    logic [mchs_pkg::DATA_W-1:0] mask;
    if (cmd == mchs_pkg::CMD_CREATE) begin
      bytes = (esz == 0) ? 1 : ((esz > mchs_pkg::MAX_ELEMENT_BYTES)
                                ? mchs_pkg::MAX_ELEMENT_BYTES : esz);
      cost  = bytes * mchs_pkg::HISTORY_DEPTH;
      s = -1;
      for (int k = mchs_pkg::MAX_STACKS - 1; k >= 0; k--)
        if (!ch_live[k]) s = k;
      if (s < 0 || cost > budget_left) begin
        expected_rsp_q.push_back(make_beat(mchs_pkg::ST_FULL, '0, '0, 0, 0, 1'b1));
        return;
      end
      ch_live[s]  = 1'b1;
      ch_id[s]    = id_counter;
      ch_bytes[s] = bytes;
      ch_fill[s]  = 0;
      ch_head[s]  = 0;
      budget_left -= cost;
      last_created_id = id_counter;
      expected_rsp_q.push_back(make_beat(mchs_pkg::ST_OK, id_counter, '0, 0, 0, 1'b1));
      id_counter = id_counter + 1'b1;
      if (id_counter == '0) id_counter = mchs_pkg::ID_W'(1);
      return;
    end
    if (cmd > mchs_pkg::CMD_READ_ALL) return;

    s = find_channel(id);
    if (s < 0) begin
      expected_rsp_q.push_back(make_beat(mchs_pkg::ST_INVALID, '0, '0, 0, 0, 1'b1));
      return;
    end

    case (cmd)
      mchs_pkg::CMD_REMOVE: begin
        ch_live[s] = 1'b0;
        budget_left += ch_bytes[s] * mchs_pkg::HISTORY_DEPTH;
        ch_fill[s] = 0;
        ch_head[s] = 0;
        expected_rsp_q.push_back(make_beat(mchs_pkg::ST_OK, '0, '0, 0, 0, 1'b1));
      end
      mchs_pkg::CMD_WRITE: begin
        pos  = (ch_fill[s] > 0) ? (ch_head[s] + 1) % mchs_pkg::HISTORY_DEPTH : 0;
        mask = (ch_bytes[s] >= 8) ? '1 : ((64'd1 << (ch_bytes[s] * 8)) - 64'd1);
        hist_mem[s][pos] = data & mask;
        ch_head[s] = pos;
        if (ch_fill[s] < mchs_pkg::HISTORY_DEPTH) ch_fill[s]++;
        expected_rsp_q.push_back(make_beat(mchs_pkg::ST_OK, '0, '0, 0, ch_fill[s], 1'b1));
      end
      default: begin
        if (ch_fill[s] == 0) begin
          expected_rsp_q.push_back(make_beat(mchs_pkg::ST_EMPTY, '0, '0, 0, 0, 1'b1));
        end else if (cmd == mchs_pkg::CMD_READ_LATEST) begin
          expected_rsp_q.push_back(make_beat(mchs_pkg::ST_OK, '0, hist_mem[s][ch_head[s]], 0,
                                             ch_fill[s], 1'b1));
        end else begin
          for (int k = 0; k < ch_fill[s]; k++) begin
            pos = (ch_head[s] + mchs_pkg::HISTORY_DEPTH - k) % mchs_pkg::HISTORY_DEPTH;
            expected_rsp_q.push_back(make_beat(mchs_pkg::ST_OK, '0, hist_mem[s][pos], k,
                                               ch_fill[s], (k + 1 == ch_fill[s])));
          end
        end
      end
    endcase
  endfunction

  function automatic void check_field(string fname, logic [63:0] exp_v, logic [63:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, fname, exp_v, got_v);
      error_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual status %0d data %h",
                 $time, rsp_if.status, rsp_if.read_data);
        error_count++;
      end else begin
        exp_beat = expected_rsp_q.pop_front();
        check_field("status", exp_beat.status, rsp_if.status);
        check_field("new_id", exp_beat.new_id, rsp_if.new_id);
        check_field("read_data", exp_beat.data, rsp_if.read_data);
        check_field("entry_index", exp_beat.idx, rsp_if.entry_index);
        check_field("entry_count", exp_beat.count, rsp_if.entry_count);
        check_field("last", exp_beat.last, rsp_if.last);
        beats_checked++;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      rx_hold_left--;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d beats still expected", $time, expected_rsp_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_cmd(input logic [mchs_pkg::CMD_W-1:0] cmd,
                          input logic [mchs_pkg::ID_W-1:0] id,
                          input logic [mchs_pkg::ESZ_W-1:0] esz,
                          input logic [mchs_pkg::DATA_W-1:0] data);
    @(posedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) @(posedge clk);
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= cmd;
    cmd_if.chan_id    <= id;
    cmd_if.elem_bytes <= esz;
    cmd_if.entry_data <= data;
    do @(posedge clk); while (!cmd_if.ready);
    cmd_if.valid <= 1'b0;
    predict_history_cmd(cmd, id, esz, data);
    cmds_sent++;
    cmd_hist[cmd]++;
  endtask

  task automatic wait_drained();
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic clear_channels();
    int s;
    s = first_live_slot();
    while (s >= 0) begin
      send_cmd(mchs_pkg::CMD_REMOVE, ch_id[s], '0, '0);
      s = first_live_slot();
    end
  endtask

  task automatic test_directed();
    logic [mchs_pkg::ID_W-1:0] ch_small, ch_wide, ch_rgb;
    send_cmd(mchs_pkg::CMD_CREATE, '0, 4'd0, '0);
    ch_small = last_created_id;
    send_cmd(mchs_pkg::CMD_CREATE, '1, 4'd15, '1);
    ch_wide = last_created_id;
    send_cmd(mchs_pkg::CMD_CREATE, 8'h5A, 4'd8, '0);
    send_cmd(mchs_pkg::CMD_CREATE, 8'hA5, 4'd3, '0);
    ch_rgb = last_created_id;
    send_cmd(mchs_pkg::CMD_READ_LATEST, ch_small, '0, '0);
    send_cmd(mchs_pkg::CMD_READ_ALL, ch_wide, '0, '0);
    // nine writes wrap the ring of the 3-byte channel
    for (int i = 0; i < mchs_pkg::HISTORY_DEPTH + 1; i++)
      send_cmd(mchs_pkg::CMD_WRITE, ch_rgb, '1,
               (i % 2) ? '1 : (64'h0123_4567_89AB_CDEF ^ mchs_pkg::DATA_W'(i)));
    send_cmd(mchs_pkg::CMD_READ_LATEST, ch_rgb, '0, '0);
    send_cmd(mchs_pkg::CMD_READ_ALL, ch_rgb, '0, '0);
    send_cmd(mchs_pkg::CMD_REMOVE, '0, '0, '0);
    send_cmd(mchs_pkg::CMD_WRITE, '1, '0, '1);
    send_cmd(mchs_pkg::CMD_READ_LATEST, 8'd200, '0, '0);
    send_cmd(mchs_pkg::CMD_READ_ALL, '0, '0, '0);
    send_cmd(CMD_RSVD_FIRST, ch_rgb, 4'd1, '1);
    send_cmd(CMD_RSVD_LAST, ch_rgb, 4'd1, '1);
    send_cmd(mchs_pkg::CMD_REMOVE, ch_wide, '0, '0);
    send_cmd(mchs_pkg::CMD_WRITE, ch_wide, '0, '1);
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    logic [mchs_pkg::ID_W-1:0] ch;
    send_cmd(mchs_pkg::CMD_CREATE, '0, 4'd8, '0);
    ch = last_created_id;
    wait_drained();
    rx_hold_left = HOLD_CYCLES;
    for (int i = 0; i < 10; i++)
      send_cmd(mchs_pkg::CMD_WRITE, ch, '0, {$urandom, $urandom});
    send_cmd(mchs_pkg::CMD_READ_ALL, ch, '0, '0);
    wait_drained();
  endtask

  task automatic test_slot_full();
    clear_channels();
    for (int i = 0; i < mchs_pkg::MAX_STACKS; i++)
      send_cmd(mchs_pkg::CMD_CREATE, '0, 4'd8, '0);
    send_cmd(mchs_pkg::CMD_CREATE, '0, 4'd8, '0);
    send_cmd(mchs_pkg::CMD_CREATE, '0, 4'd0, '0);
    send_cmd(mchs_pkg::CMD_REMOVE, ch_id[mchs_pkg::MAX_STACKS / 2], '0, '0);
    send_cmd(mchs_pkg::CMD_CREATE, '0, 4'd8, '0);
    wait_drained();
  endtask

  function automatic logic [mchs_pkg::ID_W-1:0] pick_chan_id();
    logic [mchs_pkg::ID_W-1:0] ids[$];
    for (int s = 0; s < mchs_pkg::MAX_STACKS; s++)
      if (ch_live[s]) ids.push_back(ch_id[s]);
    if (ids.size() != 0 && $urandom_range(0, 99) < 85)
      return ids[$urandom_range(0, ids.size() - 1)];
    return mchs_pkg::ID_W'($urandom_range(0, 255));
  endfunction

  task automatic test_random(input int n_items, input int tx_pct, input int rx_pct);
    int r;
    logic [mchs_pkg::CMD_W-1:0] cmd;
    logic [mchs_pkg::DATA_W-1:0] data;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12)      cmd = mchs_pkg::CMD_CREATE;
      else if (r < 22) cmd = mchs_pkg::CMD_REMOVE;
      else if (r < 58) cmd = mchs_pkg::CMD_WRITE;
      else if (r < 74) cmd = mchs_pkg::CMD_READ_LATEST;
      else if (r < 94) cmd = mchs_pkg::CMD_READ_ALL;
      else             cmd = mchs_pkg::CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
      r = $urandom_range(0, 99);
      data = (r < 8) ? '1 : ((r < 12) ? '0 : {$urandom, $urandom});
      send_cmd(cmd, pick_chan_id(), mchs_pkg::ESZ_W'($urandom_range(0, 15)), data);
    end
    wait_drained();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
  endtask

  task automatic test_slot_reuse();
    logic [mchs_pkg::ID_W-1:0] keep_id;
    clear_channels();
    send_cmd(mchs_pkg::CMD_CREATE, '0, 4'd1, '0);
    send_cmd(mchs_pkg::CMD_CREATE, '0, 4'd4, '0);
    keep_id = last_created_id;
    for (int i = 0; i < 3; i++)
      send_cmd(mchs_pkg::CMD_WRITE, keep_id, '0, {$urandom, $urandom});
    // keeper sits above the lowest slot, so freed slots below it get reused
    send_cmd(mchs_pkg::CMD_CREATE, '0, 4'd1, '0);
    send_cmd(mchs_pkg::CMD_REMOVE, ch_id[0], '0, '0);
    send_cmd(mchs_pkg::CMD_CREATE, '0, 4'd2, '0);
    send_cmd(mchs_pkg::CMD_READ_LATEST, keep_id, '0, '0);
    send_cmd(mchs_pkg::CMD_WRITE, keep_id, '0, '1);
    send_cmd(mchs_pkg::CMD_READ_ALL, keep_id, '0, '0);
    send_cmd(mchs_pkg::CMD_REMOVE, keep_id, '0, '0);
    send_cmd(mchs_pkg::CMD_READ_ALL, keep_id, '0, '0);
    send_cmd(mchs_pkg::CMD_REMOVE, keep_id, '0, '0);
    wait_drained();
  endtask

  initial begin
    rst_n             = 1'b0;
    cmd_if.valid      = 1'b0;
    cmd_if.command    = mchs_pkg::CMD_CREATE;
    cmd_if.chan_id    = '0;
    cmd_if.elem_bytes = '0;
    cmd_if.entry_data = '0;
    for (int i = 0; i < 8; i++) cmd_hist[i] = 0;
    reset_shadow();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_output_backpressure();
    test_slot_full();
    test_random(40, 0, 0);
    test_random(40, 73, 0);
    test_random(40, 0, 73);
    test_random(40, 23, 23);
    test_slot_reuse();

    if (expected_rsp_q.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, expected_rsp_q.size());
      error_count++;
    end
    $display("Ran %0d commands (create %0d, remove %0d, write %0d, read latest %0d, ",
             cmds_sent, cmd_hist[mchs_pkg::CMD_CREATE], cmd_hist[mchs_pkg::CMD_REMOVE],
             cmd_hist[mchs_pkg::CMD_WRITE], cmd_hist[mchs_pkg::CMD_READ_LATEST]);
    $display("read all %0d, reserved %0d); %0d result beats checked, %0d errors",
             cmd_hist[mchs_pkg::CMD_READ_ALL],
             cmds_sent - cmd_hist[mchs_pkg::CMD_CREATE] - cmd_hist[mchs_pkg::CMD_REMOVE]
             - cmd_hist[mchs_pkg::CMD_WRITE] - cmd_hist[mchs_pkg::CMD_READ_LATEST]
             - cmd_hist[mchs_pkg::CMD_READ_ALL],
             beats_checked, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/mchs_pkg.sv
rtl/mchs_cmd_if.sv
rtl/mchs_rsp_if.sv
rtl/mchs_entry_ram.sv
rtl/multi_channel_history_store_core.sv
tb/tb_top.sv
